// ===== src/bba_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, constants and helpers of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MAX_BLOCKS = 32;
    localparam int ADDR_WIDTH = 32;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int SIZE_W     = 16;
    localparam int NBLK_W     = 6;
    // an in-range offset is below MAX_BLOCKS * 2^SIZE_W
    localparam int OFF_W      = IDX_W + SIZE_W;
    localparam int TOTAL_W    = NBLK_W + SIZE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int STEP_W     = $clog2(IDX_W + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 2'd2;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_EXHAUSTED   = 3'd1,
        STAT_NULL        = 3'd2,
        STAT_RANGE       = 3'd3,
        STAT_MISALIGNED  = 3'd4,
        STAT_NOT_ALLOC   = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        OP_ALLOC,
        OP_FREE,
        OP_CLEAR,
        OP_NOP,
        OP_REJECT
    } op_kind_t;

    typedef enum logic [1:0] {
        MAP_KEEP,
        MAP_SET,
        MAP_CLEAR,
        MAP_WIPE
    } map_act_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_ADDR,
        BK_WRITE
    } back_state_t;

    typedef struct packed {
        cmd_t                  cmd;
        logic [ADDR_WIDTH-1:0] free_address;
    } in_item_t;

    typedef struct packed {
        status_t               status;
        logic [ADDR_WIDTH-1:0] block_address;
        logic [IDX_W-1:0]      block_number;
        logic [CNT_W-1:0]      used_blocks;
    } out_item_t;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0] pool_base;
        logic [SIZE_W-1:0]     block_bytes;
        logic [NBLK_W-1:0]     blocks_in_use;
    } cfg_t;

    // classified request passed from front to back
    typedef struct packed {
        op_kind_t         kind;
        status_t          status;
        logic [OFF_W-1:0] offset;
    } op_t;

    // block count saturated to the capacity
    function automatic logic [NBLK_W-1:0] eff_blocks(input logic [NBLK_W-1:0] n);
        logic [NBLK_W-1:0] r;
        r = (n > NBLK_W'(MAX_BLOCKS)) ? NBLK_W'(MAX_BLOCKS) : n;
        return r;
    endfunction

    // index of the lowest set bit, 0 when none
    function automatic logic [IDX_W-1:0] lowest_set(input logic [MAX_BLOCKS-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/bba_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bba_front
// Accepts request items and classifies them: null and range checks of a
// free address, offset into the pool, pushed into the request queue.
// ----------------------------------------------------------------------------
module bba_front (
    input  wire                logic in_valid,
    output                     logic in_stall,
    input  bba_pkg::in_item_t  in_item,
    input  bba_pkg::cfg_t      cfg,
    output                     logic push_valid,
    output bba_pkg::op_t       push_op,
    input  wire                logic q_full
);
    import bba_pkg::*;

    logic [NBLK_W-1:0]     n_eff;
    logic [TOTAL_W-1:0]    total;
    logic [ADDR_WIDTH-1:0] off_full;
    logic                  in_range;

    // pool span and offset of the address
    assign n_eff    = eff_blocks(cfg.blocks_in_use);
    assign total    = TOTAL_W'(n_eff) * TOTAL_W'(cfg.block_bytes);
    assign off_full = in_item.free_address - cfg.pool_base;
    assign in_range = (off_full < ADDR_WIDTH'(total));

    assign in_stall   = q_full;
    assign push_valid = in_valid && !q_full;

    // classification
    always_comb
    begin
        push_op.kind   = OP_NOP;
        push_op.status = STAT_OK;
        push_op.offset = off_full[OFF_W-1:0];
        case (in_item.cmd)
            CMD_ALLOC: push_op.kind = OP_ALLOC;
            CMD_FREE:
            begin
                if (in_item.free_address == '0) begin
                    push_op.kind   = OP_REJECT;
                    push_op.status = STAT_NULL;
                end else if (!in_range) begin
                    push_op.kind   = OP_REJECT;
                    push_op.status = STAT_RANGE;
                end else begin
                    push_op.kind   = OP_FREE;
                end
            end
            CMD_CLEAR: push_op.kind = OP_CLEAR;
            default:   push_op.kind = OP_NOP;
        endcase
    end

endmodule
`default_nettype wire

// ===== src/bba_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bba_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module bba_queue (
    input  wire          logic clk,
    input  wire          logic rst_n,
    input  wire          logic push_valid,
    input  bba_pkg::op_t push_op,
    output               logic q_full,
    input  wire          logic pop,
    output               logic q_valid,
    output bba_pkg::op_t head_op
);
    import bba_pkg::*;

    op_t        entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign q_full  = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign head_op = entry_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push_valid;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push_valid) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push_valid) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push_valid)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue pop while empty");

endmodule
`default_nettype wire

// ===== src/bba_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bba_back
// Carries out classified items: lowest-free search and address for an
// allocate, bit-per-cycle quotient of the offset for a free, map update,
// block count and the output register.
// ----------------------------------------------------------------------------
module bba_back (
    input  wire              logic clk,
    input  wire              logic rst_n,
    input  bba_pkg::cfg_t    cfg,
    input  wire              logic q_valid,
    input  bba_pkg::op_t     head_op,
    output                   logic pop,
    output                   logic out_valid,
    input  wire              logic out_stall,
    output bba_pkg::out_item_t out_item
);
    import bba_pkg::*;

    back_state_t           state_reg, state_next;
    map_act_t              act_reg, act_next;
    status_t               status_reg, status_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [OFF_W-1:0]      prod_reg, prod_next;
    logic [OFF_W-1:0]      rem_reg, rem_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [ADDR_WIDTH-1:0] addr_reg, addr_next;
    logic [MAX_BLOCKS-1:0] map_reg, map_next;
    logic [CNT_W-1:0]      used_reg, used_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_item_reg, out_item_next;

    logic [NBLK_W-1:0]     n_eff;
    logic [MAX_BLOCKS:0]   limit_wide;
    logic [MAX_BLOCKS-1:0] vacant_mask;
    logic [OFF_W-1:0]      trial;
    logic                  fits;
    logic [OFF_W-1:0]      rem_after;
    logic [IDX_W-1:0]      idx_after;
    logic                  load_out;

    // blocks that may be handed out
    assign n_eff       = eff_blocks(cfg.blocks_in_use);
    assign limit_wide  = ((MAX_BLOCKS + 1)'(1) << n_eff) - (MAX_BLOCKS + 1)'(1);
    assign vacant_mask = ~map_reg & limit_wide[MAX_BLOCKS-1:0];

    // one quotient bit per cycle
    assign trial     = OFF_W'(cfg.block_bytes) << step_reg;
    assign fits      = (rem_reg >= trial);
    assign rem_after = fits ? (rem_reg - trial) : rem_reg;
    assign idx_after = fits ? (idx_reg | (IDX_W'(1) << step_reg)) : idx_reg;

    assign load_out  = (state_reg == BK_WRITE) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        status_next    = status_reg;
        idx_next       = idx_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        addr_next      = addr_reg;
        map_next       = map_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_item_next  = out_item_reg;
        pop            = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid) begin
                    pop         = 1'b1;
                    act_next    = MAP_KEEP;
                    status_next = STAT_OK;
                    idx_next    = '0;
                    addr_next   = '0;
                    state_next  = BK_WRITE;
                    case (head_op.kind)
                        OP_ALLOC:
                        begin
                            if (vacant_mask == '0) begin
                                status_next = STAT_EXHAUSTED;
                            end else begin
                                idx_next   = lowest_set(vacant_mask);
                                prod_next  = OFF_W'(lowest_set(vacant_mask))
                                           * OFF_W'(cfg.block_bytes);
                                act_next   = MAP_SET;
                                state_next = BK_ADDR;
                            end
                        end
                        OP_FREE:
                        begin
                            rem_next   = head_op.offset;
                            step_next  = STEP_W'(IDX_W - 1);
                            state_next = BK_DIVIDE;
                        end
                        OP_CLEAR:  act_next    = MAP_WIPE;
                        OP_REJECT: status_next = head_op.status;
                        default:   act_next    = MAP_KEEP;
                    endcase
                end
            end
            BK_ADDR:
            begin
                addr_next  = cfg.pool_base + ADDR_WIDTH'(prod_reg);
                state_next = BK_WRITE;
            end
            BK_DIVIDE:
            begin
                rem_next  = rem_after;
                idx_next  = idx_after;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    state_next = BK_WRITE;
                    if (rem_after != '0) begin
                        status_next = STAT_MISALIGNED;
                        idx_next    = '0;
                    end else if (!map_reg[idx_after]) begin
                        status_next = STAT_NOT_ALLOC;
                        idx_next    = '0;
                    end else begin
                        act_next    = MAP_CLEAR;
                    end
                end
            end
            BK_WRITE:
            begin
                if (load_out) begin
                    case (act_reg)
                        MAP_SET:
                        begin
                            map_next  = map_reg | (MAX_BLOCKS'(1) << idx_reg);
                            used_next = used_reg + CNT_W'(1);
                        end
                        MAP_CLEAR:
                        begin
                            map_next  = map_reg & ~(MAX_BLOCKS'(1) << idx_reg);
                            used_next = used_reg - CNT_W'(1);
                        end
                        MAP_WIPE:
                        begin
                            map_next  = '0;
                            used_next = '0;
                        end
                        default:
                        begin
                            map_next  = map_reg;
                        end
                    endcase
                    out_valid_next              = 1'b1;
                    out_item_next.status        = status_reg;
                    out_item_next.block_address = addr_reg;
                    out_item_next.block_number  = idx_reg;
                    out_item_next.used_blocks   = used_next;
                    state_next                  = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= BK_IDLE;
            map_reg       <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            map_reg       <= map_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        status_reg   <= status_next;
        idx_reg      <= idx_next;
        prod_reg     <= prod_next;
        rem_reg      <= rem_next;
        step_reg     <= step_next;
        addr_reg     <= addr_next;
        out_item_reg <= out_item_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count above capacity");

    a_count_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg == CNT_W'($countones(map_reg)))
        else $error("block count out of step with map");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DIVIDE) |->
            ((OFF_W + 1)'(rem_reg)
             < ((OFF_W + 1)'(cfg.block_bytes) << (step_reg + STEP_W'(1)))))
        else $error("partial remainder too large");

    a_set_takes_free: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && act_reg == MAP_SET) |-> !map_reg[idx_reg])
        else $error("allocate of a block already taken");

endmodule
`default_nettype wire

// ===== src/bitmap_block_allocator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// Fixed-block pool allocator with one allocated bit per block.
// ----------------------------------------------------------------------------
// An allocate finds the lowest free block and then forms its address; a free
// runs a five-step long division of the offset by the block size; clear and
// rejected requests go straight to the map update and the result register.
// The back end takes one item at a time and waits while the output stalls.
// A two-entry queue lets items be accepted while the back end is busy.
// Reset: map empty, count 0, pool_base 4096, block_bytes 64, 32 blocks.
module bitmap_block_allocator_core (
    input  wire                 logic clk,
    input  wire                 logic rst_n,
    input  wire                 logic in_valid,
    output                      logic in_stall,
    input  bba_pkg::in_item_t   in_item,
    output                      logic out_valid,
    input  wire                 logic out_stall,
    output bba_pkg::out_item_t  out_item,
    input  wire                 logic cfg_valid,
    output                      logic cfg_ready,
    input  wire logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bba_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bba_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic push_valid;
    op_t  push_op;
    logic q_full;
    logic pop;
    logic q_valid;
    op_t  head_op;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_POOL_BASE:     cfg_next.pool_base     = cfg_data[ADDR_WIDTH-1:0];
                CFG_BLOCK_BYTES:   cfg_next.block_bytes   = cfg_data[SIZE_W-1:0];
                CFG_BLOCKS_IN_USE: cfg_next.blocks_in_use = cfg_data[NBLK_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.pool_base     <= ADDR_WIDTH'(4096);
            cfg_reg.block_bytes   <= SIZE_W'(64);
            cfg_reg.blocks_in_use <= NBLK_W'(32);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // request classification
    bba_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_op    (push_op),
        .q_full     (q_full)
    );

    // queue between front and back
    bba_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_op    (push_op),
        .q_full     (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .head_op    (head_op)
    );

    // execution and result
    bba_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .head_op   (head_op),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
`default_nettype wire

// ===== test/bitmap_block_allocator_core_tb.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core_tb
// Self-checking bench for the bitmap block allocator. Requests go in through
// the stall handshake while an in-bench allocator model tracks the block map
// and pool settings. Every response is checked in order, field by field.
// The run has directed cases first, then random traffic under three idle
// patterns, with the pool reprogrammed between bursts.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core_tb;
    import bba_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int REPORT_LIMIT   = 10;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // allocator model state, starting from the reset settings
    logic [MAX_BLOCKS-1:0] pool_map  = '0;
    logic [31:0]           cfg_base  = 32'd4096;
    logic [15:0]           cfg_bytes = 16'd64;
    logic [5:0]            cfg_count = 6'd32;

    out_item_t pending_responses[$];
    out_item_t oldest_response;
    int        fail_count    = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        quiet_cycles  = 0;

    bitmap_block_allocator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // block count after saturation at the capacity
    function automatic int managed_blocks();
        return (cfg_count > 6'd32) ? MAX_BLOCKS : int'(cfg_count);
    endfunction

    // byte address of a block under the current settings
    function automatic logic [31:0] block_base(input int idx);
        return cfg_base + 32'(idx) * 32'(cfg_bytes);
    endfunction

    // response of the allocator to one request, updating the map
    function automatic out_item_t pool_response(input in_item_t req);
        out_item_t   rsp;
        int          n;
        int          idx;
        logic [32:0] window;
        logic [31:0] open_slots;
        logic [31:0] offset;
        logic [31:0] span;
        rsp = '0;
        rsp.status = STAT_OK;
        n = managed_blocks();
        window = (33'd1 << n) - 33'd1;
        case (req.cmd)
            CMD_ALLOC:
            begin
                open_slots = ~pool_map & window[31:0];
                if (open_slots == '0) begin
                    rsp.status = STAT_EXHAUSTED;
                end else begin
                    idx = 0;
                    while (!open_slots[idx]) begin
                        idx++;
                    end
                    pool_map[idx] = 1'b1;
                    rsp.block_address = block_base(idx);
                    rsp.block_number = IDX_W'(idx);
                end
            end
            CMD_FREE:
            begin
                // offset wraps modulo the address space
                offset = req.free_address - cfg_base;
                span = 32'(n) * 32'(cfg_bytes);
                if (req.free_address == '0) begin
                    rsp.status = STAT_NULL;
                end else if (offset >= span || cfg_bytes == '0) begin
                    rsp.status = STAT_RANGE;
                end else if (offset % 32'(cfg_bytes) != '0) begin
                    rsp.status = STAT_MISALIGNED;
                end else begin
                    idx = int'(offset / 32'(cfg_bytes));
                    if (!pool_map[idx]) begin
                        rsp.status = STAT_NOT_ALLOC;
                    end else begin
                        pool_map[idx] = 1'b0;
                        rsp.block_number = IDX_W'(idx);
                    end
                end
            end
            CMD_CLEAR:
            begin
                pool_map = '0;
            end
            default:
            begin
            end
        endcase
        rsp.used_blocks = CNT_W'($countones(pool_map));
        return rsp;
    endfunction

    // model update on accepted requests and register writes
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall) begin
            pending_responses.push_back(pool_response(in_item));
        end
        if (rst_n && cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_POOL_BASE:     cfg_base  = cfg_data;
                CFG_BLOCK_BYTES:   cfg_bytes = cfg_data[15:0];
                CFG_BLOCKS_IN_USE: cfg_count = cfg_data[5:0];
                default:           ;
            endcase
        end
    end

    // response checking against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_responses.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("unexpected item: status %0d addr %h block %0d used %0d",
                             out_item.status, out_item.block_address,
                             out_item.block_number, out_item.used_blocks);
                end
            end else begin
                oldest_response = pending_responses.pop_front();
                if (out_item.status !== oldest_response.status ||
                    out_item.block_address !== oldest_response.block_address ||
                    out_item.block_number !== oldest_response.block_number ||
                    out_item.used_blocks !== oldest_response.used_blocks) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("mismatch: exp status %0d addr %h block %0d used %0d",
                                 oldest_response.status, oldest_response.block_address,
                                 oldest_response.block_number,
                                 oldest_response.used_blocks);
                        $display("          got status %0d addr %h block %0d used %0d",
                                 out_item.status, out_item.block_address,
                                 out_item.block_number, out_item.used_blocks);
                    end
                end
            end
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL bitmap_block_allocator_core");
            $finish;
        end
    end

    // one request item, held until accepted
    task automatic send_request(input cmd_t kind, input logic [31:0] address);
        in_item_t req;
        req.cmd = kind;
        req.free_address = address;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= req;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // stop sending until every response is back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_responses.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // reprogram the whole pool once idle
    task automatic set_pool(input logic [31:0] base, input logic [31:0] bytes,
                            input logic [31:0] count);
        wait_for_drain();
        write_register(CFG_POOL_BASE, base);
        write_register(CFG_BLOCK_BYTES, bytes);
        write_register(CFG_BLOCKS_IN_USE, count);
        cfg_valid <= 1'b0;
    endtask

    // reset settings: allocate, free and every rejection of a free
    task automatic test_default_pool();
        send_request(CMD_ALLOC, $urandom);
        send_request(CMD_ALLOC, $urandom);
        send_request(CMD_FREE, 32'd4160);
        send_request(CMD_FREE, 32'd4160);
        send_request(CMD_FREE, 32'd0);
        send_request(CMD_FREE, 32'd4097);
        send_request(CMD_FREE, 32'd4095);
        send_request(CMD_FREE, 32'hFFFF_FFFF);
        send_request(CMD_FREE, 32'd4096 + 32'd2048);
        send_request(CMD_NOP, $urandom);
        send_request(CMD_CLEAR, $urandom);
    endtask

    // pool across the top of the address space, exhaustion, then shrink
    task automatic test_wrap_and_shrink();
        set_pool(32'hFFFF_FFA0, 32'd64, 32'd3);
        repeat (4) send_request(CMD_ALLOC, $urandom);
        send_request(CMD_FREE, 32'h0000_0021);
        send_request(CMD_FREE, 32'h0000_0020);
        set_pool(32'hFFFF_FFA0, 32'd64, 32'd1);
        send_request(CMD_FREE, 32'hFFFF_FFE0);
        send_request(CMD_ALLOC, $urandom);
        send_request(CMD_CLEAR, $urandom);
    endtask

    // zero blocks, zero block size, count above capacity, widest settings
    task automatic test_degenerate_sizes();
        set_pool(32'd1, 32'h0000_FFFF, 32'd0);
        send_request(CMD_ALLOC, $urandom);
        send_request(CMD_FREE, 32'd1);
        send_request(CMD_FREE, 32'd0);
        set_pool(32'h8000_0000, 32'hABCD_0000, 32'h0000_1A28);
        send_request(CMD_ALLOC, $urandom);
        send_request(CMD_ALLOC, $urandom);
        send_request(CMD_FREE, 32'h8000_0000);
        send_request(CMD_CLEAR, $urandom);
        set_pool(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_ALLOC, $urandom);
        send_request(CMD_ALLOC, $urandom);
        send_request(CMD_FREE, 32'h0000_FFFE);
    endtask

    // random bursts, each under a freshly drawn pool setting
    task automatic test_random_traffic(input int item_count);
        int          sent;
        int          burst;
        int          pick;
        int          idx;
        int          n;
        int          tries;
        logic [31:0] base;
        logic [31:0] bytes;
        logic [31:0] count;
        logic [31:0] addr;
        sent = 0;
        while (sent < item_count) begin
            case ($urandom_range(4))
                0:       base = 32'd1;
                1:       base = 32'hFFFF_FFFF;
                2:       base = 32'hFFFF_FFFF - $urandom_range(0, 4095);
                3:       base = $urandom;
                default: base = $urandom_range(1, 32'h0010_0000);
            endcase
            case ($urandom_range(7))
                0:       bytes = 32'd0;
                1:       bytes = 32'd1;
                2:       bytes = 32'h0000_FFFF;
                3:       bytes = 32'd1 << $urandom_range(0, 15);
                default: bytes = $urandom_range(1, 256);
            endcase
            case ($urandom_range(7))
                0:       count = 32'd0;
                1:       count = $urandom_range(33, 63);
                2:       count = 32'd32;
                3:       count = 32'd1;
                default: count = $urandom_range(2, 31);
            endcase
            // junk above the register widths must be dropped
            bytes = bytes | ($urandom & 32'hFFFF_0000);
            count = count | ($urandom & 32'hFFFF_FFC0);
            set_pool(base, bytes, count);
            burst = $urandom_range(20, 60);
            for (int k = 0; k < burst && sent < item_count; k++) begin
                n = managed_blocks();
                pick = $urandom_range(99);
                if (pick < 40) begin
                    send_request(CMD_ALLOC, $urandom);
                end else if (pick < 83) begin
                    // mostly blocks that are held, sometimes knocked off alignment
                    idx = (n > 0) ? $urandom_range(0, n - 1) : 0;
                    tries = 0;
                    while (n > 0 && !pool_map[idx] && tries < 6) begin
                        idx = $urandom_range(0, n - 1);
                        tries++;
                    end
                    addr = block_base(idx);
                    if (pick >= 75 && cfg_bytes > 16'd1) begin
                        addr = addr + $urandom_range(1, cfg_bytes - 1);
                    end
                    send_request(CMD_FREE, addr);
                end else if (pick < 90) begin
                    send_request(CMD_FREE, $urandom);
                end else if (pick < 93) begin
                    send_request(CMD_FREE, 32'd0);
                end else if (pick < 97) begin
                    send_request(CMD_CLEAR, $urandom);
                end else begin
                    send_request(CMD_NOP, $urandom);
                end
                sent++;
            end
        end
    endtask

    // test sequence
    initial
    begin
        send_idle_pct = 30;
        recv_idle_pct = 83;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_default_pool();
        test_wrap_and_shrink();
        test_degenerate_sizes();
        test_random_traffic(275);
        send_idle_pct = 83;
        recv_idle_pct = 30;
        test_random_traffic(275);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(270);
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending_responses.size() == 0) begin
            $display("PASS bitmap_block_allocator_core");
        end else begin
            $display("FAIL bitmap_block_allocator_core");
        end
        $finish;
    end

endmodule
